>>> hdl/rrwt_pkg.sv
// Shared widths, constants and controller/datapath handshake types for the round robin calculator.
`timescale 1ns / 1ps
`default_nettype none

package rrwt_pkg;

  // Field widths
  localparam int BURST_W  = 16;
  localparam int SLICE_W  = 16;
  localparam int TIME_W   = 22;
  localparam int JOBNUM_W = 7;

  // Register reset value and default store depth
  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd4;
  localparam int DEFAULT_MAX_JOBS = 16;

  // Remainder unit: one dividend bit per step
  localparam int DIV_STEPS = BURST_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic mem_wr;     // store the incoming burst word
    logic latch_b;    // capture the burst of the current job, seed remainder unit
    logic div_step;   // advance the remainder unit one bit
    logic calc_r;     // form the slice-rounded limits, clear the accumulator
    logic acc_issue;  // a store read for the accumulation is in flight
    logic out_load;   // load the result register
    logic last;       // current job is the last of the batch
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_taken;  // result word accepted downstream
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/rrwt_ctrl.sv
// Controller state machine: batch loading, per-job sequencing and result handoff.
`timescale 1ns / 1ps
`default_nettype none

module rrwt_ctrl #(
  parameter int MAX_JOBS = rrwt_pkg::DEFAULT_MAX_JOBS,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             last_job,
  input  wire rrwt_pkg::sts_t   sts,
  output rrwt_pkg::cmd_t        cmd,
  output logic [IDX_W-1:0]      addr,
  output logic [IDX_W-1:0]      job_idx
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_FETCH,
    S_LATCH,
    S_DIV,
    S_ROUND,
    S_ACC,
    S_DRAIN,
    S_EMIT,
    S_WAIT
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          job_count;
  logic [IDX_W-1:0]          k;
  logic [IDX_W-1:0]          j;
  logic [rrwt_pkg::STEP_W-1:0] step;

  logic in_accept;
  logic store_ok;
  logic k_last;
  logic j_last;

  assign in_ready  = (state == S_LOAD);
  assign in_accept = in_valid && in_ready;
  assign store_ok  = (job_count < CNT_W'(MAX_JOBS));
  assign k_last    = ((CNT_W'(k) + CNT_W'(1)) == job_count);
  assign j_last    = ((CNT_W'(j) + CNT_W'(1)) == job_count);
  assign job_idx   = k;

  // Select the store address: fill pointer, scan index or current job
  always_comb begin
    unique case (state)
      S_LOAD:  addr = job_count[IDX_W-1:0];
      S_ACC:   addr = j;
      default: addr = k;
    endcase
  end

  // Decode commands from the state
  always_comb begin
    cmd           = '0;
    cmd.mem_wr    = in_accept && store_ok;
    cmd.latch_b   = (state == S_LATCH);
    cmd.div_step  = (state == S_DIV);
    cmd.calc_r    = (state == S_ROUND);
    cmd.acc_issue = (state == S_ACC);
    cmd.out_load  = (state == S_EMIT);
    cmd.last      = k_last;
  end

  // Hold state, counters and indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      job_count <= '0;
      k         <= '0;
      j         <= '0;
      step      <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_accept) begin
            if (store_ok) begin
              job_count <= job_count + CNT_W'(1);
            end
            if (last_job) begin
              k     <= '0;
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_LATCH;
        end
        S_LATCH: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          step <= step + rrwt_pkg::STEP_W'(1);
          if (step == rrwt_pkg::STEP_W'(rrwt_pkg::DIV_STEPS - 1)) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          j     <= '0;
          state <= S_ACC;
        end
        S_ACC: begin
          if (j_last) begin
            state <= S_DRAIN;
          end else begin
            j <= j + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (sts.out_taken) begin
            if (k_last) begin
              job_count <= '0;
              state     <= S_LOAD;
            end else begin
              k     <= k + IDX_W'(1);
              state <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    job_count <= CNT_W'(MAX_JOBS))
    else $error("job count beyond store depth");

  // A batch under calculation always holds at least one job
  a_batch_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (job_count != '0))
    else $error("calculation started on an empty batch");

endmodule

`default_nettype wire

>>> hdl/rrwt_dp.sv
// Datapath: burst store, slice register, remainder unit, finish-time accumulator, result register.
`timescale 1ns / 1ps
`default_nettype none

module rrwt_dp #(
  parameter int MAX_JOBS = rrwt_pkg::DEFAULT_MAX_JOBS,
  parameter int IDX_W    = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rrwt_pkg::cmd_t                   cmd,
  output rrwt_pkg::sts_t                        sts,
  input  wire logic [IDX_W-1:0]                 addr,
  input  wire logic [IDX_W-1:0]                 job_idx,
  input  wire logic [rrwt_pkg::BURST_W-1:0]     burst_time,
  input  wire logic                             cfg_we,
  input  wire logic [rrwt_pkg::SLICE_W-1:0]     cfg_wdata,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [rrwt_pkg::JOBNUM_W-1:0]         job_number,
  output logic [rrwt_pkg::TIME_W-1:0]           waiting_time,
  output logic [rrwt_pkg::TIME_W-1:0]           turnaround_time,
  output logic                                  last_result
);

  localparam int BW = rrwt_pkg::BURST_W;
  localparam int TW = rrwt_pkg::TIME_W;

  logic [BW-1:0]                burst_store [MAX_JOBS];
  logic [BW-1:0]                rd_data;
  logic [IDX_W-1:0]             rd_idx;
  logic                         issue_q;
  logic [rrwt_pkg::SLICE_W-1:0] time_slice;
  logic [BW-1:0]                b_cur;
  logic [BW-1:0]                rem;
  logic [BW-1:0]                dvd;
  logic [BW:0]                  r_hi;
  logic [BW:0]                  r_lo;
  logic [TW-1:0]                acc;

  logic [BW-1:0] q_eff;
  logic [BW:0]   rem_sh;
  logic          rem_fit;
  logic [BW-1:0] rem_next;
  logic [BW:0]   pad;
  logic [BW:0]   r_hi_next;
  logic [BW:0]   data_ext;
  logic [BW:0]   term;
  logic          b_zero;

  // Zero slice runs as one unit
  assign q_eff  = (time_slice == '0) ? BW'(1) : time_slice;
  assign b_zero = (b_cur == '0);

  // Burst store: one write and one registered read per cycle, both at addr
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      burst_store[addr] <= burst_time;
    end
    rd_data <= burst_store[addr];
    rd_idx  <= addr;
  end

  // Slice register and read-in-flight flag
  always_ff @(posedge clk) begin
    if (rst) begin
      time_slice <= rrwt_pkg::SLICE_RESET;
      issue_q    <= 1'b0;
    end else begin
      if (cfg_we) begin
        time_slice <= cfg_wdata;
      end
      issue_q <= cmd.acc_issue;
    end
  end

  // Restoring remainder step: burst mod slice
  assign rem_sh   = {rem, dvd[BW-1]};
  assign rem_fit  = (rem_sh >= {1'b0, q_eff});
  assign rem_next = rem_fit ? BW'(rem_sh - {1'b0, q_eff}) : rem_sh[BW-1:0];

  // Round the burst up to a whole number of slices
  assign pad       = (rem == '0) ? '0 : {1'b0, BW'(q_eff - rem)};
  assign r_hi_next = {1'b0, b_cur} + pad;

  // Time a scanned job has run when the current job finishes
  assign data_ext = {1'b0, rd_data};
  always_comb begin
    if (rd_idx < job_idx) begin
      term = (data_ext < r_hi) ? data_ext : r_hi;
    end else if (rd_idx == job_idx) begin
      term = data_ext;
    end else begin
      term = (data_ext < r_lo) ? data_ext : r_lo;
    end
  end

  // Remainder unit, limits and accumulator
  always_ff @(posedge clk) begin
    if (cmd.latch_b) begin
      b_cur <= rd_data;
      dvd   <= rd_data;
      rem   <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      dvd <= {dvd[BW-2:0], 1'b0};
    end
    if (cmd.calc_r) begin
      r_hi <= r_hi_next;
      r_lo <= r_hi_next - {1'b0, q_eff};
      acc  <= '0;
    end else if (issue_q) begin
      acc <= acc + TW'(term);
    end
  end

  // Result register: load on command, drop on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      job_number      <= rrwt_pkg::JOBNUM_W'(job_idx) + rrwt_pkg::JOBNUM_W'(1);
      waiting_time    <= b_zero ? '0 : (acc - TW'(b_cur));
      turnaround_time <= b_zero ? '0 : acc;
      last_result     <= cmd.last;
    end
  end

  assign sts.out_taken = out_valid && out_ready;

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid)
    else $error("result register overwritten while valid");

endmodule

`default_nettype wire

>>> hdl/round_robin_wait_time_calc_top.sv
// Top level of the round robin waiting and turnaround time calculator.
//
// Input channel (in_valid/in_ready): one word per job carrying burst_time and
// last_job. Words load one per cycle while the block is collecting a batch;
// words beyond MAX_JOBS are dropped, and a word with last_job set closes the
// batch (even when dropped).
// Output channel (out_valid/out_ready): one word per stored job, in job order,
// with job_number, waiting_time, turnaround_time; last_result marks the final one.
// Config: cfg_we writes cfg_wdata into the time slice (reset 4, zero runs as 1).
// Sequence: for a batch of n jobs each result takes a store read, the
// bit-serial remainder unit, a rounding step, n store reads through the
// single-port burst store for the accumulation, and the result register
// load. in_ready stays low until the final result of the batch is taken.
// Stall: a held result stops the controller until out_ready; nothing is lost.
// Reset: clears the controller and the batch fill count and sets the time
// slice to 4; the burst store is not cleared and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_wait_time_calc_top #(
  parameter int MAX_JOBS = rrwt_pkg::DEFAULT_MAX_JOBS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rrwt_pkg::BURST_W-1:0]     burst_time,
  input  wire logic                             last_job,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [rrwt_pkg::JOBNUM_W-1:0]         job_number,
  output logic [rrwt_pkg::TIME_W-1:0]           waiting_time,
  output logic [rrwt_pkg::TIME_W-1:0]           turnaround_time,
  output logic                                  last_result,
  input  wire logic                             cfg_we,
  input  wire logic [rrwt_pkg::SLICE_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  rrwt_pkg::cmd_t   cmd;
  rrwt_pkg::sts_t   sts;
  logic [IDX_W-1:0] addr;
  logic [IDX_W-1:0] job_idx;

  rrwt_ctrl #(
    .MAX_JOBS (MAX_JOBS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .last_job (last_job),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr),
    .job_idx  (job_idx)
  );

  rrwt_dp #(
    .MAX_JOBS (MAX_JOBS),
    .IDX_W    (IDX_W)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .addr            (addr),
    .job_idx         (job_idx),
    .burst_time      (burst_time),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .job_number      (job_number),
    .waiting_time    (waiting_time),
    .turnaround_time (turnaround_time),
    .last_result     (last_result)
  );

  // Loading and reporting never overlap
  a_phase_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input open while a result is pending");

  // Taking the final result reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_result) |=> in_ready)
    else $error("input not reopened after final result");

endmodule

`default_nettype wire
